// ===== hdl/tcpd_pkg.sv =====
package tcpd_pkg;

	// Default capacity and register reset value.
	localparam int DEPTH_DEFAULT = 16;
	localparam logic [3:0] THRESHOLD_RESET = 4'd4;

	// Width of the occupancy field in a result item.
	localparam int OCC_W = 5;

	// Operation codes carried in the mode field.
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// End codes carried in the end_used field.
	localparam logic END_FRONT = 1'b0;
	localparam logic END_BACK  = 1'b1;

	// Status codes carried in the status field.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Saturation limit of the stored visit count.
	localparam logic [7:0] VISITS_MAX = 8'hFF;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	// One input item.
	typedef struct packed {
		logic        mode;
		logic [15:0] entry_tag;
		logic [3:0]  entry_priority;
		logic [7:0]  visit_count;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [1:0]       status;
		logic             end_used;
		logic [15:0]      out_tag;
		logic [3:0]       out_priority;
		logic [7:0]       out_visits;
		logic [OCC_W-1:0] occupancy;
	} out_item_t;

	// One stored entry of the circular buffer.
	typedef struct packed {
		logic [15:0] tag;
		logic [3:0]  prio;
		logic [7:0]  visits;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/tcpd_ram.sv =====
module tcpd_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ===== hdl/two_class_priority_deque.sv =====
// Bounded double-ended queue of DEPTH entries held in a circular buffer.
// The input channel (in_valid, in_stall, in_item) carries one operation per
// item: an insert places the entry at the front when its priority is at or
// above front_threshold and at the back otherwise; a remove takes the end
// entry with the higher priority, the front on a tie. Every input item yields
// exactly one result item on the output channel (out_valid, out_stall,
// out_item) with a status, the end touched and the occupancy afterwards.
// An insert, and a remove on an empty queue, register their result, which
// appears the cycle after acceptance. A remove on a non-empty queue first
// waits in S_READ for the registered read of the entry memory; the next item
// is accepted once its result is loaded. The user must write the threshold
// through cfg_wr_en and cfg_wr_data only while the block is idle; the block
// does not enforce this. Reset empties the queue, sets the threshold to 4
// and drops any pending result; the memory contents are not cleared. While
// the receiver stalls, the result item is held and in_stall is raised once a
// new result would need the output register.
module two_class_priority_deque
	import tcpd_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Circular index helpers.
	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
		wrap_inc = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
		wrap_dec = (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
	endfunction

	state_t     state_q, state_d;
	logic [AW-1:0] front_q, front_d;
	logic [AW-1:0] back_q, back_d;
	logic [CW-1:0] count_q, count_d;
	logic [3:0] thresh_q;
	logic       out_valid_q;
	out_item_t  out_item_q, out_item_d;
	logic       load_out;
	logic       in_acc;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic [ENTRY_W-1:0] rd_raw_a, rd_raw_b;
	entry_t        front_entry, back_entry;

	// Entry memory: port A reads the front slot, port B the back slot.
	tcpd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_entry),
		.rd_addr_a (front_q),
		.rd_data_a (rd_raw_a),
		.rd_addr_b (wrap_dec(back_q)),
		.rd_data_b (rd_raw_b)
	);

	assign front_entry = entry_t'(rd_raw_a);
	assign back_entry  = entry_t'(rd_raw_b);

	// Handshake: take an item only when idle and the output register can load.
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Entry written on an insert, with the saturating visit count.
	always_comb begin
		wr_entry.tag    = in_item.entry_tag;
		wr_entry.prio   = in_item.entry_priority;
		wr_entry.visits = (in_item.visit_count == VISITS_MAX) ? VISITS_MAX
			: in_item.visit_count + 8'd1;
	end

	// Next state, pointer updates and result formation.
	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		back_d     = back_q;
		count_d    = count_q;
		wr_en      = 1'b0;
		wr_addr    = back_q;
		load_out   = 1'b0;
		out_item_d = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_item.mode == MODE_INSERT) begin
						load_out = 1'b1;
						if (count_q == CW'(DEPTH)) begin
							out_item_d.status   = ST_FULL;
							out_item_d.end_used = END_FRONT;
						end else begin
							wr_en   = 1'b1;
							count_d = count_q + CW'(1);
							out_item_d.status = ST_DONE;
							if (in_item.entry_priority >= thresh_q) begin
								front_d = wrap_dec(front_q);
								wr_addr = wrap_dec(front_q);
								out_item_d.end_used = END_FRONT;
							end else begin
								wr_addr = back_q;
								back_d  = wrap_inc(back_q);
								out_item_d.end_used = END_BACK;
							end
						end
						out_item_d.occupancy = OCC_W'(count_d);
					end else if (count_q == '0) begin
						load_out = 1'b1;
						out_item_d.status    = ST_EMPTY;
						out_item_d.end_used  = END_FRONT;
						out_item_d.occupancy = OCC_W'(count_q);
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				load_out = 1'b1;
				count_d  = count_q - CW'(1);
				out_item_d.status = ST_DONE;
				if (back_entry.prio > front_entry.prio) begin
					back_d = wrap_dec(back_q);
					out_item_d.end_used     = END_BACK;
					out_item_d.out_tag      = back_entry.tag;
					out_item_d.out_priority = back_entry.prio;
					out_item_d.out_visits   = back_entry.visits;
				end else begin
					front_d = wrap_inc(front_q);
					out_item_d.end_used     = END_FRONT;
					out_item_d.out_tag      = front_entry.tag;
					out_item_d.out_priority = front_entry.prio;
					out_item_d.out_visits   = front_entry.visits;
				end
				out_item_d.occupancy = OCC_W'(count_d);
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			thresh_q    <= THRESHOLD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_q     <= front_d;
			back_q      <= back_d;
			count_q     <= count_d;
			out_valid_q <= load_out || (out_valid_q && out_stall);
			if (cfg_wr_en) begin
				thresh_q <= cfg_wr_data;
			end
		end
	end

	// Result register, held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_item_q <= out_item_d;
		end
	end

endmodule
